[rtl/core/ggbb_pkg.sv]
// Shared constants, types and helpers for the glyph grid bounding box block.
package ggbb_pkg;

  localparam int MAX_CELL_SIDE = 64;
  localparam int GLYPHS        = 128;
  localparam int SHEET_COLS    = 16;
  localparam int SHEET_ROWS    = 8;

  localparam int CFG_W   = 7;
  localparam int SIDE_W  = $clog2(MAX_CELL_SIDE);
  localparam int GIDX_W  = $clog2(GLYPHS);
  localparam int SCOL_W  = $clog2(SHEET_COLS);
  localparam int SROW_W  = $clog2(SHEET_ROWS);
  localparam int COLOR_W = 32;
  localparam int POS_W   = 10;
  localparam int SPACE_W = 6;

  localparam logic [GIDX_W-1:0] GLYPH_A = GIDX_W'(65);

  typedef enum logic {
    CFG_CELL_WIDTH  = 1'b0,
    CFG_CELL_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic capture;
    logic pix_upd;
    logic out_load;
  } ggbb_cmd_t;

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > MAX_CELL_SIDE) begin
      r = CFG_W'(MAX_CELL_SIDE);
    end
    return r;
  endfunction

endpackage

[rtl/core/ggbb_ctrl.sv]
// Controller: request handshake, two-step sequencing and result valid tracking.
module ggbb_ctrl
  import ggbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      mode_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ggbb_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   mode_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.pix_upd  = (state_q == ST_EXEC) && (mode_q == MODE_PIXEL);
    cmd_o.out_load = (state_q == ST_EXEC) && (mode_q == MODE_QUERY) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_PIXEL;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd_o.pix_upd || cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ggbb_dp.sv]
// Datapath: config registers, raster counters, edge memory, trackers, result registers.
module ggbb_dp
  import ggbb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ggbb_cmd_t          cmd_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               mode_i,
  input  logic [COLOR_W-1:0] pixel_color_i,
  input  logic [GIDX_W-1:0]  glyph_index_i,
  output logic [POS_W-1:0]   glyph_x_o,
  output logic [POS_W-1:0]   glyph_y_o,
  output logic [CFG_W-1:0]   glyph_w_o,
  output logic [CFG_W-1:0]   glyph_h_o,
  output logic [SPACE_W-1:0] space_width_o,
  output logic [CFG_W-1:0]   line_advance_o
);

  logic [CFG_W-1:0]   cell_width_q, cell_height_q;
  logic [COLOR_W-1:0] background_q, color_q;
  logic [SIDE_W-1:0]  col_in_cell_q, row_in_cell_q;
  logic [SCOL_W-1:0]  cell_column_q;
  logic [SROW_W-1:0]  cell_row_q;
  logic [GLYPHS-1:0]  inked_q;
  logic [CFG_W-1:0]   top_trim_q, a_bottom_q;
  logic [GIDX_W-1:0]  index_q;

  logic [2*SIDE_W-1:0] edge_mem [GLYPHS];
  logic [SIDE_W-1:0]   left_rd_q, right_rd_q;

  logic [POS_W-1:0]   glyph_x_q, glyph_y_q;
  logic [CFG_W-1:0]   glyph_w_q, glyph_h_q, line_advance_q;
  logic [SPACE_W-1:0] space_width_q;

  logic [CFG_W-1:0]   cw, ch;
  logic [GIDX_W-1:0]  g_cur;
  logic               img_start;
  logic [COLOR_W-1:0] bg_eff;
  logic               ink;
  logic               flag_eff;
  logic [CFG_W-1:0]   tt_eff, ab_eff, ab_mid, top_trim_d, a_bottom_d;
  logic [CFG_W-1:0]   row7;
  logic [SIDE_W-1:0]  left_d, right_d;
  logic [GLYPHS-1:0]  inked_d;
  logic               col_wrap, ccol_wrap, row_wrap;

  logic               q_flag;
  logic [POS_W:0]     x_prod, y_prod;
  logic [POS_W:0]     x_sum;
  logic [CFG_W-1:0]   w_val, h_val, adv_val;

  assign cw    = eff_size(cell_width_q);
  assign ch    = eff_size(cell_height_q);
  assign g_cur = GIDX_W'({cell_row_q, cell_column_q});
  assign img_start = (col_in_cell_q == '0) && (row_in_cell_q == '0) &&
                     (cell_column_q == '0) && (cell_row_q == '0);

  // pixel update
  always_comb begin
    bg_eff   = img_start ? color_q : background_q;
    ink      = (color_q != bg_eff);
    flag_eff = img_start ? 1'b0 : inked_q[g_cur];
    tt_eff   = img_start ? ch : top_trim_q;
    ab_eff   = img_start ? ch : a_bottom_q;
    row7     = CFG_W'(row_in_cell_q);

    if (!flag_eff) begin
      left_d  = col_in_cell_q;
      right_d = col_in_cell_q;
    end else begin
      left_d  = (col_in_cell_q < left_rd_q) ? col_in_cell_q : left_rd_q;
      right_d = (col_in_cell_q > right_rd_q) ? col_in_cell_q : right_rd_q;
    end

    inked_d = img_start ? '0 : inked_q;
    if (ink) begin
      inked_d[g_cur] = 1'b1;
    end

    top_trim_d = (ink && (row7 < tt_eff)) ? row7 : tt_eff;
    ab_mid     = (ink && (g_cur == GLYPH_A) && (row7 > ab_eff)) ? row7 : ab_eff;
    a_bottom_d = (ink && (g_cur == GLYPH_A) && (ab_mid == ch) && (row7 < ch)) ? row7 : ab_mid;

    col_wrap  = ((CFG_W'(col_in_cell_q) + CFG_W'(1)) >= cw);
    ccol_wrap = (cell_column_q == SCOL_W'(SHEET_COLS - 1));
    row_wrap  = ((CFG_W'(row_in_cell_q) + CFG_W'(1)) >= ch);
  end

  // query result
  always_comb begin
    q_flag  = inked_q[index_q];
    x_prod  = (POS_W+1)'(cw) * (POS_W+1)'(index_q[SCOL_W-1:0]);
    y_prod  = (POS_W+1)'(ch) * (POS_W+1)'(index_q[GIDX_W-1:SCOL_W]);
    x_sum   = x_prod + (q_flag ? (POS_W+1)'(left_rd_q) : '0);
    w_val   = q_flag ? CFG_W'(right_rd_q - left_rd_q) + CFG_W'(1) : cw;
    h_val   = (ch > top_trim_q) ? ch - top_trim_q : '0;
    adv_val = (a_bottom_q > top_trim_q) ? a_bottom_q - top_trim_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      color_q <= pixel_color_i;
      index_q <= glyph_index_i;
      {left_rd_q, right_rd_q} <= edge_mem[(mode_i == MODE_QUERY) ? glyph_index_i : g_cur];
    end
    if (cmd_i.pix_upd && ink) begin
      edge_mem[g_cur] <= {left_d, right_d};
    end
    if (cmd_i.out_load) begin
      glyph_x_q      <= x_sum[POS_W-1:0];
      glyph_y_q      <= POS_W'(y_prod + (POS_W+1)'(top_trim_q));
      glyph_w_q      <= w_val;
      glyph_h_q      <= h_val;
      space_width_q  <= SPACE_W'(cw >> 1);
      line_advance_q <= adv_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q  <= CFG_W'(8);
      cell_height_q <= CFG_W'(8);
      background_q  <= '0;
      col_in_cell_q <= '0;
      row_in_cell_q <= '0;
      cell_column_q <= '0;
      cell_row_q    <= '0;
      inked_q       <= '0;
      top_trim_q    <= CFG_W'(8);
      a_bottom_q    <= CFG_W'(8);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_CELL_WIDTH:  cell_width_q  <= cfg_data_i;
          CFG_CELL_HEIGHT: cell_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.pix_upd) begin
        background_q <= bg_eff;
        inked_q      <= inked_d;
        top_trim_q   <= top_trim_d;
        a_bottom_q   <= a_bottom_d;
        if (col_wrap) begin
          col_in_cell_q <= '0;
          if (ccol_wrap) begin
            cell_column_q <= '0;
            if (row_wrap) begin
              row_in_cell_q <= '0;
              cell_row_q    <= (cell_row_q == SROW_W'(SHEET_ROWS - 1)) ? '0
                               : cell_row_q + SROW_W'(1);
            end else begin
              row_in_cell_q <= row_in_cell_q + SIDE_W'(1);
            end
          end else begin
            cell_column_q <= cell_column_q + SCOL_W'(1);
          end
        end else begin
          col_in_cell_q <= col_in_cell_q + SIDE_W'(1);
        end
      end
    end
  end

  assign glyph_x_o      = glyph_x_q;
  assign glyph_y_o      = glyph_y_q;
  assign glyph_w_o      = glyph_w_q;
  assign glyph_h_o      = glyph_h_q;
  assign space_width_o  = space_width_q;
  assign line_advance_o = line_advance_q;

endmodule

[rtl/core/glyph_grid_bounding_boxes.sv]
// Top level of the glyph grid bounding box extractor.
// A request (pixel or query) first reads the cell's left/right edge entry from a
// 128-entry memory with a registered read port, then writes the updated entry back
// for an inked pixel or loads the result register; a new request is taken only
// once the last is done. A query waits to load its result only while the previous
// result is still held unaccepted. The first pixel of each sheet sets the
// background and clears the per-cell ink flags at once; there is no clearing
// pass. Configuration writes are always accepted.
module glyph_grid_bounding_boxes
  import ggbb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [COLOR_W-1:0] pixel_color_i,
  input  logic [GIDX_W-1:0]  glyph_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [POS_W-1:0]   glyph_x_o,
  output logic [POS_W-1:0]   glyph_y_o,
  output logic [CFG_W-1:0]   glyph_w_o,
  output logic [CFG_W-1:0]   glyph_h_o,
  output logic [SPACE_W-1:0] space_width_o,
  output logic [CFG_W-1:0]   line_advance_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  ggbb_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ggbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ggbb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .pixel_color_i  (pixel_color_i),
    .glyph_index_i  (glyph_index_i),
    .glyph_x_o      (glyph_x_o),
    .glyph_y_o      (glyph_y_o),
    .glyph_w_o      (glyph_w_o),
    .glyph_h_o      (glyph_h_o),
    .space_width_o  (space_width_o),
    .line_advance_o (line_advance_o)
  );

endmodule

[sim/glyph_grid_bounding_boxes_tb.sv]
// Self-checking testbench for the glyph grid bounding box extractor.
`timescale 1ns / 100ps

module glyph_grid_bounding_boxes_tb;
  import ggbb_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    logic [SPACE_W-1:0] space;
    logic [CFG_W-1:0]   adv;
  } glyph_box_t;

  typedef struct {
    bit                 is_cfg;
    cfg_idx_e           reg_sel;
    logic [CFG_W-1:0]   reg_val;
    mode_e              mode;
    logic [COLOR_W-1:0] color;
    logic [GIDX_W-1:0]  idx;
    bit                 typed;
    glyph_box_t         want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic [COLOR_W-1:0] pixel_color_i;
  logic [GIDX_W-1:0]  glyph_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [POS_W-1:0]   glyph_x_o;
  logic [POS_W-1:0]   glyph_y_o;
  logic [CFG_W-1:0]   glyph_w_o;
  logic [CFG_W-1:0]   glyph_h_o;
  logic [SPACE_W-1:0] space_width_o;
  logic [CFG_W-1:0]   line_advance_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [CFG_W-1:0]   cfg_data_i;

  glyph_grid_bounding_boxes u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .pixel_color_i  (pixel_color_i),
    .glyph_index_i  (glyph_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .glyph_x_o      (glyph_x_o),
    .glyph_y_o      (glyph_y_o),
    .glyph_w_o      (glyph_w_o),
    .glyph_h_o      (glyph_h_o),
    .space_width_o  (space_width_o),
    .line_advance_o (line_advance_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // sheet tracker state
  logic [CFG_W-1:0]   cell_w_reg, cell_h_reg;
  logic [COLOR_W-1:0] bg_color;
  logic [SIDE_W-1:0]  col_in, row_in;
  logic [SCOL_W-1:0]  cell_col;
  logic [SROW_W-1:0]  cell_row;
  logic [GLYPHS-1:0]  inked;
  logic [SIDE_W-1:0]  left_col [GLYPHS];
  logic [SIDE_W-1:0]  right_col [GLYPHS];
  logic [CFG_W-1:0]   top_trim, a_bottom;

  glyph_box_t expected_boxes [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  bit         send_quiet = 1'b0;
  bit         recv_quiet = 1'b0;

  function automatic int cell_side(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_CELL_SIDE) return MAX_CELL_SIDE;
    return int'(v);
  endfunction

  function automatic int idle_cycles(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic track_pixel(logic [COLOR_W-1:0] color);
    int cw, ch;
    logic [GIDX_W-1:0] g;
    cw = cell_side(cell_w_reg);
    ch = cell_side(cell_h_reg);
    if (col_in == '0 && row_in == '0 && cell_col == '0 && cell_row == '0) begin
      bg_color = color;
      inked    = '0;
      top_trim = CFG_W'(ch);
      a_bottom = CFG_W'(ch);
    end
    g = {cell_row, cell_col};
    if (color != bg_color) begin
      if (!inked[g]) begin
        inked[g]     = 1'b1;
        left_col[g]  = col_in;
        right_col[g] = col_in;
      end else begin
        if (col_in < left_col[g]) left_col[g] = col_in;
        if (col_in > right_col[g]) right_col[g] = col_in;
      end
      if (CFG_W'(row_in) < top_trim) top_trim = CFG_W'(row_in);
      if (g == GLYPH_A && CFG_W'(row_in) > a_bottom) a_bottom = CFG_W'(row_in);
      if (g == GLYPH_A && int'(a_bottom) == ch && int'(row_in) < ch) a_bottom = CFG_W'(row_in);
    end
    if (int'(col_in) + 1 >= cw) begin
      col_in = '0;
      if (int'(cell_col) + 1 >= SHEET_COLS) begin
        cell_col = '0;
        if (int'(row_in) + 1 >= ch) begin
          row_in   = '0;
          cell_row = cell_row + SROW_W'(1);
        end else begin
          row_in = row_in + SIDE_W'(1);
        end
      end else begin
        cell_col = cell_col + SCOL_W'(1);
      end
    end else begin
      col_in = col_in + SIDE_W'(1);
    end
  endtask

  function automatic glyph_box_t predict_box(logic [GIDX_W-1:0] idx);
    int cw, ch, col, row, x, w, h, adv;
    glyph_box_t box;
    cw  = cell_side(cell_w_reg);
    ch  = cell_side(cell_h_reg);
    col = int'(idx[3:0]);
    row = int'(idx[6:4]);
    if (inked[idx]) begin
      x = cw * col + int'(left_col[idx]);
      w = int'(right_col[idx]) - int'(left_col[idx]) + 1;
    end else begin
      x = cw * col;
      w = cw;
    end
    h   = (ch > int'(top_trim)) ? ch - int'(top_trim) : 0;
    adv = (a_bottom > top_trim) ? int'(a_bottom) - int'(top_trim) : 0;
    box.x     = POS_W'(x);
    box.y     = POS_W'(ch * row + int'(top_trim));
    box.w     = CFG_W'(w);
    box.h     = CFG_W'(h);
    box.space = SPACE_W'(cw / 2);
    box.adv   = CFG_W'(adv);
    return box;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic push_request(mode_e mode, logic [COLOR_W-1:0] color,
                              logic [GIDX_W-1:0] idx, bit typed = 1'b0,
                              glyph_box_t want = '0);
    int gap;
    gap = idle_cycles(send_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    mode_i        = mode;
    pixel_color_i = color;
    glyph_index_i = idx;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode == MODE_PIXEL) track_pixel(color);
    else expected_boxes.push_back(typed ? want : predict_box(idx));
  endtask

  task automatic write_cfg(cfg_idx_e sel, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == CFG_CELL_WIDTH) cell_w_reg = val;
    else cell_h_reg = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait out pending results and let the last request drain
  task automatic settle();
    int guard;
    guard = 0;
    while (expected_boxes.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int count);
    logic [COLOR_W-1:0] color;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    settle();
    write_cfg(CFG_CELL_WIDTH, w);
    write_cfg(CFG_CELL_HEIGHT, h);
    send_quiet = ($urandom_range(0, 3) == 0);
    recv_quiet = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        push_request(MODE_QUERY, $urandom, GIDX_W'($urandom_range(0, GLYPHS - 1)));
      end else begin
        if (col_in == '0 && row_in == '0 && cell_col == '0 && cell_row == '0)
          color = $urandom;
        else
          color = ($urandom_range(0, 9) < 7) ? bg_color : $urandom;
        push_request(MODE_PIXEL, color, GIDX_W'($urandom));
      end
    end
  endtask

  function automatic stim_row_t blank_row();
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_sel = CFG_CELL_WIDTH;
    r.reg_val = '0;
    r.mode    = MODE_PIXEL;
    r.color   = '0;
    r.idx     = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic stim_row_t pix(logic [COLOR_W-1:0] color);
    stim_row_t r;
    r = blank_row();
    r.mode  = MODE_PIXEL;
    r.color = color;
    return r;
  endfunction

  function automatic stim_row_t ask(int idx);
    stim_row_t r;
    r = blank_row();
    r.mode = MODE_QUERY;
    r.idx  = GIDX_W'(idx);
    return r;
  endfunction

  function automatic stim_row_t ask_typed(int idx, int x, int y, int w,
                                          int h, int sp, int adv);
    stim_row_t r;
    r = ask(idx);
    r.typed      = 1'b1;
    r.want.x     = POS_W'(x);
    r.want.y     = POS_W'(y);
    r.want.w     = CFG_W'(w);
    r.want.h     = CFG_W'(h);
    r.want.space = SPACE_W'(sp);
    r.want.adv   = CFG_W'(adv);
    return r;
  endfunction

  function automatic stim_row_t set_reg(cfg_idx_e sel, int val);
    stim_row_t r;
    r = blank_row();
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  // result side: random back-pressure, compare against oldest expectation
  initial begin
    int stall;
    glyph_box_t want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_cycles(recv_quiet);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_boxes.size() == 0) begin
        report_mismatch("result with no query pending");
      end else begin
        want = expected_boxes.pop_front();
        check_field("glyph_x", int'(glyph_x_o), int'(want.x));
        check_field("glyph_y", int'(glyph_y_o), int'(want.y));
        check_field("glyph_w", int'(glyph_w_o), int'(want.w));
        check_field("glyph_h", int'(glyph_h_o), int'(want.h));
        check_field("space_width", int'(space_width_o), int'(want.space));
        check_field("line_advance", int'(line_advance_o), int'(want.adv));
      end
    end
  end

  initial begin
    #800000;
    $display("glyph_grid_bounding_boxes_tb: errors");
    $finish;
  end

  initial begin
    int phase_w [7] = '{1, 0, 1, 2, 127, 64, 3};
    int phase_h [7] = '{1, 0, 2, 2, 2, 64, 127};
    int phase_n [7] = '{130, 30, 230, 80, 40, 30, 40};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_PIXEL;
    pixel_color_i = '0;
    glyph_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CELL_WIDTH;
    cfg_data_i    = '0;
    cell_w_reg    = CFG_W'(8);
    cell_h_reg    = CFG_W'(8);
    bg_color      = '0;
    col_in        = '0;
    row_in        = '0;
    cell_col      = '0;
    cell_row      = '0;
    inked         = '0;
    top_trim      = CFG_W'(8);
    a_bottom      = CFG_W'(8);

    // empty sheet at reset sizes, then a shrunken cell height below the trim
    directed_rows.push_back(ask_typed(0, 0, 8, 8, 0, 4, 0));
    directed_rows.push_back(ask_typed(127, 120, 64, 8, 0, 4, 0));
    directed_rows.push_back(ask_typed(65, 8, 40, 8, 0, 4, 0));
    directed_rows.push_back(set_reg(CFG_CELL_HEIGHT, 2));
    directed_rows.push_back(ask_typed(17, 8, 10, 8, 0, 4, 0));
    directed_rows.push_back(set_reg(CFG_CELL_HEIGHT, 8));
    // first sheet row of cell 0, then one inked pixel in cell 1
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'hFFFF_FFFF));
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'h8000_0001));
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'h0000_0000));
    directed_rows.push_back(pix(32'h7FFF_FFFF));
    directed_rows.push_back(ask(0));
    directed_rows.push_back(ask(1));
    directed_rows.push_back(ask(2));
    directed_rows.push_back(ask(65));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        settle();
        write_cfg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        push_request(directed_rows[i].mode, directed_rows[i].color, directed_rows[i].idx,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < 7; p++) run_phase(CFG_W'(phase_w[p]), CFG_W'(phase_h[p]), phase_n[p]);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    settle();
    if (expected_boxes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_boxes.size()));
    if (mismatch_count == 0) begin
      $display("glyph_grid_bounding_boxes_tb: clean");
    end else begin
      $display("glyph_grid_bounding_boxes_tb: errors");
    end
    $finish;
  end

endmodule
